// ----- hdl/wclru_pkg.sv -----
package wclru_pkg;

    localparam int ENTRIES    = 8;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int ADDR_W     = 24;
    localparam int BANK_W     = 8;
    localparam int REFS_W     = 8;
    localparam int STAMP_W    = 32;
    localparam int CMD_W      = 2;
    localparam int RSLOT_W    = 4;
    localparam int SIZE_W     = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int ALIGN_BITS = 4;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(24'hFFFFFF) + SIZE_W'(1);
    localparam logic [REFS_W-1:0]  REFS_MAX   = '1;
    localparam logic [RSLOT_W-1:0] PRIVATE_SLOT = RSLOT_W'(ENTRIES);

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_BANK_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOADED_BANK_SIZE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_HIT      = 3'd0,
        STAT_FILLED   = 3'd1,
        STAT_BYPASS   = 3'd2,
        STAT_REJECTED = 3'd3,
        STAT_RELEASED = 3'd4,
        STAT_PRIVATE  = 3'd5,
        STAT_IGNORED  = 3'd6,
        STAT_CLEARED  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FILL,
        S_RELEASE,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  end_addr;
        logic [REFS_W-1:0]  refs;
        logic [STAMP_W-1:0] use_stamp;
    } entry_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  aligned_base;
        logic [REFS_W-1:0]  ref_count;
        logic               evicted;
    } result_t;

endpackage

// ----- hdl/wave_cache_refcount_lru.sv -----
// Reference-counted LRU tag store for decoded wave segments; aresetn (synchronous,
// active low) empties the store and restores both bank sizes.
// An acquire that hits ends the scan early; one that misses walks all eight entries
// through the single tag RAM read port, then fills. One transaction is processed at a
// time, but the next may be accepted while a result waits in the output register.
module wave_cache_refcount_lru
    import wclru_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] cmd, [9:2] bank_id, [33:10] start_address, [57:34] end_address,
    // [61:58] release_slot, [63:62] zero
    input  logic [63:0]          s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] status, [5:3] slot, [29:6] aligned_base, [37:30] ref_count,
    // [38] evicted, [39] zero
    output logic [39:0]          m_tdata,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [SIZE_W-1:0]    cfg_wdata
);

    // Configuration registers.
    logic [SIZE_W-1:0] wave_bank_size_reg;
    logic [SIZE_W-1:0] loaded_bank_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_bank_size_reg   <= SIZE_RESET;
            loaded_bank_size_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_WAVE_BANK_SIZE:   wave_bank_size_reg   <= cfg_wdata;
                CFG_LOADED_BANK_SIZE: loaded_bank_size_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Latched input transaction.
    logic [CMD_W-1:0]   cmd_reg;
    logic [BANK_W-1:0]  bank_reg;
    logic [ADDR_W-1:0]  start_reg;
    logic [ADDR_W-1:0]  end_reg;
    logic [RSLOT_W-1:0] rslot_reg;

    // Control state. Valid bits live in flip-flops so that reset and the clear command
    // empty the store at once; the tag RAM itself is never swept.
    fsm_state_t          state_reg, state_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [STAMP_W-1:0]  use_clock_reg, use_clock_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic                vic_found_reg, vic_found_next;
    logic                vic_valid_reg, vic_valid_next;
    logic [SLOT_W-1:0]   vic_idx_reg, vic_idx_next;
    logic [STAMP_W-1:0]  vic_stamp_reg, vic_stamp_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // Tag RAM port signals.
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    entry_t              mem_wdata;
    logic [SLOT_W-1:0]   mem_raddr;
    entry_t              mem_rdata;

    wclru_tag_ram u_tag_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tdata[1:0];
            bank_reg  <= s_tdata[9:2];
            start_reg <= s_tdata[33:10];
            end_reg   <= s_tdata[57:34];
            rslot_reg <= s_tdata[61:58];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            use_clock_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            use_clock_reg <= use_clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        vic_found_reg <= vic_found_next;
        vic_valid_reg <= vic_valid_next;
        vic_idx_reg   <= vic_idx_next;
        vic_stamp_reg <= vic_stamp_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // Values derived from the latched transaction.
    logic [ADDR_W-1:0]  first_addr;
    logic               reject;
    logic [SLOT_W-1:0]  rel_idx;
    logic               entry_hit;
    logic [STAMP_W-1:0] stamp;
    logic [REFS_W-1:0]  hit_refs;

    assign first_addr = {start_reg[ADDR_W-1:ALIGN_BITS], ALIGN_BITS'(0)};
    // A segment is rejected when it runs backwards, overruns the bank, or the bank
    // has not been loaded completely.
    assign reject     = (loaded_bank_size_reg < wave_bank_size_reg)
                     || (start_reg > end_reg)
                     || (SIZE_W'(end_reg) >= wave_bank_size_reg);
    assign rel_idx    = rslot_reg[SLOT_W-1:0];
    assign entry_hit  = (mem_rdata.bank == bank_reg) && (mem_rdata.base == first_addr)
                     && (mem_rdata.end_addr == end_reg);
    assign stamp      = use_clock_reg + STAMP_W'(1);
    assign hit_refs   = (mem_rdata.refs == REFS_MAX) ? REFS_MAX
                                                     : mem_rdata.refs + REFS_W'(1);

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        use_clock_next = use_clock_reg;
        idx_next       = idx_reg;
        vic_found_next = vic_found_reg;
        vic_valid_next = vic_valid_reg;
        vic_idx_next   = vic_idx_reg;
        vic_stamp_next = vic_stamp_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = idx_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                res_next = '{status: STAT_IGNORED, default: '0};
                state_next = S_FINISH;
                unique case (cmd_reg)
                    CMD_ACQUIRE: begin
                        if (reject) begin
                            res_next.status = STAT_REJECTED;
                        end else begin
                            // Start the scan: entry 0 is read now, checked next cycle.
                            mem_raddr      = '0;
                            idx_next       = '0;
                            vic_found_next = 1'b0;
                            vic_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_RELEASE: begin
                        if (rslot_reg == PRIVATE_SLOT) begin
                            res_next.status = STAT_PRIVATE;
                        end else if (rslot_reg < PRIVATE_SLOT && valid_reg[rel_idx]) begin
                            mem_raddr  = rel_idx;
                            state_next = S_RELEASE;
                        end
                    end
                    CMD_CLEAR: begin
                        valid_next      = '0;
                        use_clock_next  = '0;
                        res_next.status = STAT_CLEARED;
                    end
                    default: ;
                endcase
            end

            S_SCAN: begin
                // mem_rdata holds entry idx_reg; the next entry is read meanwhile.
                mem_raddr = idx_reg + SLOT_W'(1);
                if (!valid_reg[idx_reg]) begin
                    // The lowest empty entry beats any occupied candidate.
                    if (!vic_found_reg || vic_valid_reg) begin
                        vic_found_next = 1'b1;
                        vic_valid_next = 1'b0;
                        vic_idx_next   = idx_reg;
                    end
                end else if (entry_hit) begin
                    mem_we         = 1'b1;
                    mem_waddr      = idx_reg;
                    mem_wdata.refs      = hit_refs;
                    mem_wdata.use_stamp = stamp;
                    use_clock_next = stamp;
                    res_next = '{status: STAT_HIT, slot: idx_reg,
                                 aligned_base: mem_rdata.base, ref_count: hit_refs,
                                 evicted: 1'b0};
                end else if (mem_rdata.refs == '0 && (!vic_found_reg
                             || (vic_valid_reg && mem_rdata.use_stamp < vic_stamp_reg))) begin
                    // Strict compare keeps the lower entry on equal stamps.
                    vic_found_next = 1'b1;
                    vic_valid_next = 1'b1;
                    vic_idx_next   = idx_reg;
                    vic_stamp_next = mem_rdata.use_stamp;
                end

                if (valid_reg[idx_reg] && entry_hit) begin
                    state_next = S_FINISH;
                end else if (idx_reg == SLOT_W'(ENTRIES - 1)) begin
                    state_next = S_FILL;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            S_FILL: begin
                if (!vic_found_reg) begin
                    res_next = '{status: STAT_BYPASS, slot: '0, aligned_base: first_addr,
                                 ref_count: '0, evicted: 1'b0};
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = vic_idx_reg;
                    mem_wdata = '{bank: bank_reg, base: first_addr, end_addr: end_reg,
                                  refs: REFS_W'(1), use_stamp: stamp};
                    valid_next[vic_idx_reg] = 1'b1;
                    use_clock_next = stamp;
                    res_next = '{status: STAT_FILLED, slot: vic_idx_reg,
                                 aligned_base: first_addr, ref_count: REFS_W'(1),
                                 evicted: vic_valid_reg};
                end
                state_next = S_FINISH;
            end

            S_RELEASE: begin
                res_next = '{status: STAT_IGNORED, slot: rel_idx, default: '0};
                if (mem_rdata.refs != '0) begin
                    mem_we         = 1'b1;
                    mem_waddr      = rel_idx;
                    mem_wdata.refs = mem_rdata.refs - REFS_W'(1);
                    res_next.status    = STAT_RELEASED;
                    res_next.ref_count = mem_rdata.refs - REFS_W'(1);
                end
                state_next = S_FINISH;
            end

            S_FINISH: begin
                // Hand the result over once the output register is free or draining.
                if (!out_valid_reg || m_tready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.evicted, out_reg.ref_count, out_reg.aligned_base,
                       out_reg.slot, out_reg.status};

endmodule

// ----- hdl/wclru_tag_ram.sv -----
module wclru_tag_ram
    import wclru_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [SLOT_W-1:0] rd_addr,
    output entry_t            rd_data
);

    // Contents need no reset: an entry's contents are only used once its valid bit is set.
    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- verif/wave_cache_refcount_lru_checker.sv -----
`timescale 1ns / 1ps

module wave_cache_refcount_lru_checker
    import wclru_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [39:0]          m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    output int unsigned          mismatches,
    output int unsigned          outstanding,
    output int unsigned          checked_count,
    output int unsigned          hit_count,
    output int unsigned          saturated_count,
    output int unsigned          fill_count,
    output int unsigned          evict_count,
    output int unsigned          bypass_count,
    output int unsigned          reject_count
);

    localparam logic [ADDR_W-1:0] ALIGN_MASK = ADDR_W'(8'h0f);

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  aligned_base;
        logic [REFS_W-1:0]  ref_count;
        logic               evicted;
    } segment_result_t;

    // Shadow copy of the tag store and of the two size registers.
    logic               tag_valid    [ENTRIES];
    logic [BANK_W-1:0]  tag_bank     [ENTRIES];
    logic [ADDR_W-1:0]  tag_base     [ENTRIES];
    logic [ADDR_W-1:0]  tag_end      [ENTRIES];
    logic [REFS_W-1:0]  tag_refs     [ENTRIES];
    logic [STAMP_W-1:0] tag_stamp    [ENTRIES];
    logic [STAMP_W-1:0] stamp_clock;
    logic [SIZE_W-1:0]  bank_size;
    logic [SIZE_W-1:0]  loaded_size;

    segment_result_t    pending_results [$];
    segment_result_t    oldest;
    segment_result_t    predicted;

    task automatic empty_store();
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            tag_valid[i] = 1'b0;
            tag_bank[i]  = '0;
            tag_base[i]  = '0;
            tag_end[i]   = '0;
            tag_refs[i]  = '0;
            tag_stamp[i] = '0;
        end
        stamp_clock = '0;
    endtask

    task automatic lookup_segment(input logic [BANK_W-1:0] bank,
                                  input logic [ADDR_W-1:0] first_byte,
                                  input logic [ADDR_W-1:0] last_byte,
                                  output segment_result_t r);
        logic [ADDR_W-1:0] base;
        int                i;
        int                victim;
        int                hit_slot;
        logic              take;
        r = '0;
        if (loaded_size < bank_size || first_byte > last_byte ||
            {1'b0, last_byte} >= bank_size) begin
            r.status = STAT_REJECTED;
            reject_count++;
        end else begin
            base     = first_byte & ~ALIGN_MASK;
            victim   = -1;
            hit_slot = -1;
            for (i = 0; i < ENTRIES && hit_slot < 0; i++) begin
                if (!tag_valid[i]) begin
                    // The lowest empty entry wins over any occupied candidate.
                    take = (victim < 0);
                    if (!take)
                        take = tag_valid[victim];
                    if (take)
                        victim = i;
                end else if (tag_bank[i] == bank && tag_base[i] == base &&
                             tag_end[i] == last_byte) begin
                    hit_slot = i;
                end else if (tag_refs[i] == '0) begin
                    take = (victim < 0);
                    if (!take)
                        take = tag_valid[victim] && (tag_stamp[i] < tag_stamp[victim]);
                    if (take)
                        victim = i;
                end
            end
            if (hit_slot >= 0) begin
                if (tag_refs[hit_slot] != REFS_MAX)
                    tag_refs[hit_slot] = tag_refs[hit_slot] + 1'b1;
                else
                    saturated_count++;
                stamp_clock         = stamp_clock + 1'b1;
                tag_stamp[hit_slot] = stamp_clock;
                r.status            = STAT_HIT;
                r.slot              = SLOT_W'(hit_slot);
                r.aligned_base      = tag_base[hit_slot];
                r.ref_count         = tag_refs[hit_slot];
                hit_count++;
            end else if (victim < 0) begin
                r.status       = STAT_BYPASS;
                r.aligned_base = base;
                bypass_count++;
            end else begin
                r.evicted         = tag_valid[victim];
                tag_valid[victim] = 1'b1;
                tag_bank[victim]  = bank;
                tag_base[victim]  = base;
                tag_end[victim]   = last_byte;
                tag_refs[victim]  = REFS_W'(1);
                stamp_clock       = stamp_clock + 1'b1;
                tag_stamp[victim] = stamp_clock;
                r.status          = STAT_FILLED;
                r.slot            = SLOT_W'(victim);
                r.aligned_base    = base;
                r.ref_count       = REFS_W'(1);
                fill_count++;
                if (r.evicted)
                    evict_count++;
            end
        end
    endtask

    task automatic drop_reference(input logic [RSLOT_W-1:0] rslot,
                                  output segment_result_t r);
        r = '0;
        if (rslot == PRIVATE_SLOT) begin
            r.status = STAT_PRIVATE;
        end else if (rslot > PRIVATE_SLOT || !tag_valid[rslot[SLOT_W-1:0]]) begin
            r.status = STAT_IGNORED;
        end else if (tag_refs[rslot[SLOT_W-1:0]] == '0) begin
            r.status = STAT_IGNORED;
            r.slot   = rslot[SLOT_W-1:0];
        end else begin
            tag_refs[rslot[SLOT_W-1:0]] = tag_refs[rslot[SLOT_W-1:0]] - 1'b1;
            r.status    = STAT_RELEASED;
            r.slot      = rslot[SLOT_W-1:0];
            r.ref_count = tag_refs[rslot[SLOT_W-1:0]];
        end
    endtask

    task automatic predict_segment(input logic [63:0] item, output segment_result_t r);
        cmd_t op;
        op = cmd_t'(item[1:0]);
        r  = '0;
        case (op)
            CMD_ACQUIRE: begin
                lookup_segment(item[9:2], item[33:10], item[57:34], r);
            end
            CMD_RELEASE: begin
                drop_reference(item[61:58], r);
            end
            CMD_CLEAR: begin
                empty_store();
                r.status = STAT_CLEARED;
            end
            default: begin
                r.status = STAT_IGNORED;
            end
        endcase
    endtask

    task automatic compare_result(input segment_result_t want, input logic [39:0] got);
        if (got[2:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got[2:0]);
            mismatches++;
        end
        if (got[5:3] !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got[5:3]);
            mismatches++;
        end
        if (got[29:6] !== want.aligned_base) begin
            $error("aligned_base: expected 0x%06h, got 0x%06h", want.aligned_base, got[29:6]);
            mismatches++;
        end
        if (got[37:30] !== want.ref_count) begin
            $error("ref_count: expected %0d, got %0d", want.ref_count, got[37:30]);
            mismatches++;
        end
        if (got[38] !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, got[38]);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            empty_store();
            bank_size       = SIZE_RESET;
            loaded_size     = SIZE_RESET;
            pending_results.delete();
            mismatches      = 0;
            checked_count   = 0;
            hit_count       = 0;
            saturated_count = 0;
            fill_count      = 0;
            evict_count     = 0;
            bypass_count    = 0;
            reject_count    = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_WAVE_BANK_SIZE)
                    bank_size = cfg_wdata;
                else if (cfg_addr == CFG_LOADED_BANK_SIZE)
                    loaded_size = cfg_wdata;
            end
            // Results are matched before the new item is queued, so a result
            // leaving on the same edge is always paired with an older item.
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result 0x%010h arrived with no transaction outstanding", m_tdata);
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    compare_result(oldest, m_tdata);
                    checked_count++;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_segment(s_tdata, predicted);
                pending_results.push_back(predicted);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- verif/wave_cache_refcount_lru_tb.sv -----
`timescale 1ns / 1ps

// Testbench top for the reference-counted wave segment cache. It generates the
// stimulus, drives the configuration registers between phases and gives the
// verdict; prediction and comparison live in the checker instantiated beside
// the block.
module wave_cache_refcount_lru_tb;
    import wclru_pkg::*;

    localparam int          POOL_SIZE    = 12;
    localparam int unsigned FULL_BANK    = 32'd16777216;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          STALL_LIMIT  = 2000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [1:0] cmd, [9:2] bank_id, [33:10] start_address, [57:34] end_address,
    // [61:58] release_slot, [63:62] zero
    logic [63:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [2:0] status, [5:3] slot, [29:6] aligned_base, [37:30] ref_count,
    // [38] evicted, [39] zero
    logic [39:0]          m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [SIZE_W-1:0]    cfg_wdata = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned checked_count;
    int unsigned hit_count;
    int unsigned saturated_count;
    int unsigned fill_count;
    int unsigned evict_count;
    int unsigned bypass_count;
    int unsigned reject_count;

    // While calm is set neither side inserts idle cycles.
    logic        calm = 1'b0;
    int unsigned quiet_cycles = 0;

    // A small pool of well-formed descriptors; acquiring from it is what
    // produces hits, LRU evictions and, once every entry is referenced,
    // bypasses. Twelve descriptors over eight entries keeps the store churning.
    logic [BANK_W-1:0] pool_bank  [POOL_SIZE];
    logic [ADDR_W-1:0] pool_first [POOL_SIZE];
    logic [ADDR_W-1:0] pool_last  [POOL_SIZE];

    always #4 aclk = ~aclk;

    wave_cache_refcount_lru u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    wave_cache_refcount_lru_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .checked_count   (checked_count),
        .hit_count       (hit_count),
        .saturated_count (saturated_count),
        .fill_count      (fill_count),
        .evict_count     (evict_count),
        .bypass_count    (bypass_count),
        .reject_count    (reject_count)
    );

    // The result side stalls about 23 percent of the time, except during
    // the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 23);
    end

    // Watchdog: the run is abandoned if no transaction moves on either
    // channel for too long. Configuration pauses and the final wait are far
    // shorter than the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("wave_cache_refcount_lru_tb: FAIL");
                $finish;
            end
        end
    end

    // Offers one item and returns at the edge on which it was accepted. The
    // valid stays high into the next item unless a random gap is inserted,
    // so it is never lowered and raised within one time step.
    task automatic put_segment(input cmd_t              op,
                               input logic [BANK_W-1:0]  bank,
                               input logic [ADDR_W-1:0]  first_byte,
                               input logic [ADDR_W-1:0]  last_byte,
                               input logic [RSLOT_W-1:0] rslot);
        if (!calm && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, rslot, last_byte, first_byte, bank, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds the sender off until every outstanding result has been taken,
    // then lets the block's longest latency pass so it is certainly idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_sizes(input int unsigned wave_bytes, input int unsigned loaded_bytes);
        write_reg(CFG_WAVE_BANK_SIZE, SIZE_W'(wave_bytes));
        write_reg(CFG_LOADED_BANK_SIZE, SIZE_W'(loaded_bytes));
    endtask

    // Fills the pool with short segments that end inside the bank, so they
    // pass the size checks whenever the loaded size covers the bank.
    task automatic make_pool(input int unsigned limit);
        int          k;
        int unsigned last_b;
        int unsigned span;
        for (k = 0; k < POOL_SIZE; k++) begin
            last_b        = $urandom_range(0, limit - 1);
            span          = $urandom_range(0, 64);
            pool_bank[k]  = BANK_W'($urandom_range(0, 255));
            pool_last[k]  = ADDR_W'(last_b);
            pool_first[k] = ADDR_W'((last_b > span) ? last_b - span : 0);
        end
    endtask

    // One random transaction: mostly acquires from the pool and releases of
    // real slots, with some raw descriptors, out-of-range releases, clears
    // and the unused command mixed in. Fields a command ignores carry noise.
    task automatic random_segment();
        int unsigned        pick;
        int unsigned        k;
        logic [RSLOT_W-1:0] rslot;
        logic [BANK_W-1:0]  junk_bank;
        logic [ADDR_W-1:0]  junk_first;
        logic [ADDR_W-1:0]  junk_last;
        pick       = $urandom_range(0, 99);
        k          = $urandom_range(0, POOL_SIZE - 1);
        junk_bank  = BANK_W'($urandom);
        junk_first = ADDR_W'($urandom);
        junk_last  = ADDR_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            rslot = RSLOT_W'($urandom_range(0, 15));
        else
            rslot = RSLOT_W'($urandom_range(0, ENTRIES));
        if (pick < 55)
            put_segment(CMD_ACQUIRE, pool_bank[k], pool_first[k], pool_last[k], rslot);
        else if (pick < 63)
            put_segment(CMD_ACQUIRE, junk_bank, junk_first, junk_last, rslot);
        else if (pick < 93)
            put_segment(CMD_RELEASE, junk_bank, junk_first, junk_last, rslot);
        else if (pick < 96)
            put_segment(CMD_CLEAR, junk_bank, junk_first, junk_last, rslot);
        else
            put_segment(CMD_UNUSED, junk_bank, junk_first, junk_last, rslot);
    endtask

    task automatic random_phase(input int count, input int unsigned limit);
        int n;
        make_pool(limit);
        for (n = 0; n < count; n++)
            random_segment();
    endtask

    initial begin
        int          k;
        int unsigned mid_size;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset sizes: alignment, a repeated hit,
        // the top of the address range, start beyond end, filling every
        // entry, a bypass with all entries referenced, release down to zero
        // and past it, eviction of the only unreferenced entry, the private
        // slot, slots beyond the store, the unused command, a clear and a
        // release of an entry the clear emptied.
        put_segment(CMD_ACQUIRE, 8'h00, 24'h000000, 24'h000000, '0);
        put_segment(CMD_ACQUIRE, 8'h00, 24'h000000, 24'h000000, '0);
        put_segment(CMD_ACQUIRE, 8'h00, 24'h00000F, 24'h00000F, '0);
        put_segment(CMD_ACQUIRE, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, '0);
        put_segment(CMD_ACQUIRE, 8'h00, 24'h000100, 24'h0000FF, '0);
        for (k = 3; k < ENTRIES; k++)
            put_segment(CMD_ACQUIRE, BANK_W'(k), ADDR_W'(k * 16), ADDR_W'(k * 16 + 3), '0);
        put_segment(CMD_ACQUIRE, 8'h5A, 24'h123456, 24'h123460, '0);
        put_segment(CMD_RELEASE, '0, '0, '0, RSLOT_W'(0));
        put_segment(CMD_RELEASE, '0, '0, '0, RSLOT_W'(0));
        put_segment(CMD_RELEASE, '0, '0, '0, RSLOT_W'(0));
        put_segment(CMD_ACQUIRE, 8'h5A, 24'h123456, 24'h123460, '0);
        put_segment(CMD_RELEASE, '0, '0, '0, PRIVATE_SLOT);
        put_segment(CMD_RELEASE, '0, '0, '0, RSLOT_W'(9));
        put_segment(CMD_RELEASE, '0, '0, '0, RSLOT_W'(15));
        put_segment(CMD_UNUSED, '0, '0, '0, '0);
        put_segment(CMD_CLEAR, '0, '0, '0, '0);
        put_segment(CMD_RELEASE, '0, '0, '0, RSLOT_W'(2));
        put_segment(CMD_ACQUIRE, 8'h00, 24'h000000, 24'h000000, '0);

        settle();
        random_phase(150, FULL_BANK);

        // One-byte bank with nothing loaded: every acquire must be rejected.
        settle();
        set_sizes(1, 0);
        random_phase(30, 1);

        // One-byte bank, fully loaded: only segments at address zero pass.
        settle();
        set_sizes(1, FULL_BANK);
        random_phase(40, 1);

        // A random bank size somewhere in the middle, loaded exactly.
        settle();
        mid_size = $urandom_range(16, FULL_BANK - 1);
        set_sizes(mid_size, mid_size);
        random_phase(150, mid_size);

        // Loaded size one byte short of a full bank.
        settle();
        set_sizes(FULL_BANK, FULL_BANK - 1);
        random_phase(20, FULL_BANK);

        // Back to full sizes. One descriptor is acquired well past the
        // reference ceiling with both sides running flat out; this is also
        // the long stretch without idle cycles.
        settle();
        set_sizes(FULL_BANK, FULL_BANK);
        make_pool(FULL_BANK);
        calm = 1'b1;
        put_segment(CMD_CLEAR, '0, '0, '0, '0);
        for (k = 0; k < 258; k++)
            put_segment(CMD_ACQUIRE, pool_bank[0], pool_first[0], pool_last[0], '0);
        for (k = 0; k < 3; k++)
            put_segment(CMD_RELEASE, '0, '0, '0, RSLOT_W'(0));
        settle();
        calm = 1'b0;

        random_phase(60, FULL_BANK);

        settle();
        @(negedge aclk);
        $display("%0d transactions checked over six size settings: %0d hits (%0d at the ceiling),",
                 checked_count, hit_count, saturated_count);
        $display("%0d fills (%0d evicting), %0d bypasses and %0d rejections.",
                 fill_count, evict_count, bypass_count, reject_count);
        if (mismatches == 0 && outstanding == 0) begin
            $display("wave_cache_refcount_lru_tb: PASS");
        end else begin
            $display("wave_cache_refcount_lru_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- wave_cache_refcount_lru.f -----
hdl/wclru_pkg.sv
hdl/wclru_tag_ram.sv
hdl/wave_cache_refcount_lru.sv
verif/wave_cache_refcount_lru_checker.sv
verif/wave_cache_refcount_lru_tb.sv
